// File: src/phtd_pkg.sv
// Shared types and constants for the phase-angle TRIAC dimmer.
package phtd_pkg;

    // Width of the ticks-since-crossing counter
    localparam int TIME_WIDTH = 15;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

    localparam int HALF_W  = 15;
    localparam int MIN_W   = 15;
    localparam int PULSE_W = 10;
    localparam int POWER_W = 10;
    localparam int DELAY_W = 15;
    localparam int PROD_W  = HALF_W + POWER_W;
    localparam int COUNT_W = 32;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_ADDR_W = 2;

    // Debounce compare width covers both the counter and the half-cycle threshold
    localparam int CMP_W = (TIME_WIDTH > HALF_W) ? TIME_WIDTH : HALF_W;

    localparam logic [POWER_W-1:0] POWER_FULL = 10'd1000;

    // floor(n / 1000) = (n * RECIP_1000) >> RECIP_SHIFT, exact for n < 2**25
    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 35;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 26'd34359739;
    localparam int MUL_W = PROD_W + RECIP_W;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_CYCLE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_DELAY  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GATE_PULSE = 2'd2;

    localparam logic [HALF_W-1:0]  HALF_CYCLE_RST = 15'd10000;
    localparam logic [MIN_W-1:0]   MIN_DELAY_RST  = 15'd100;
    localparam logic [PULSE_W-1:0] GATE_PULSE_RST = 10'd10;

    typedef struct packed {
        logic [HALF_W-1:0]  half_cycle;
        logic [MIN_W-1:0]   min_delay;
        logic [PULSE_W-1:0] gate_pulse;
    } cfg_t;

    // One registered tick on its way into the timing engine
    typedef struct packed {
        logic              zc_edge;
        logic              p_zero;
        logic              p_full;
        logic [PROD_W-1:0] prod;
    } front_t;

endpackage

// File: src/phtd_cfg_regs.sv
// Configuration register file for the dimmer.
module phtd_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [phtd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [phtd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output phtd_pkg::cfg_t                     cfg
);
    import phtd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_HALF_CYCLE: cfg_next.half_cycle = cfg_wdata[HALF_W-1:0];
                CFG_MIN_DELAY:  cfg_next.min_delay  = cfg_wdata[MIN_W-1:0];
                CFG_GATE_PULSE: cfg_next.gate_pulse = cfg_wdata[PULSE_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_cycle <= HALF_CYCLE_RST;
            cfg_reg.min_delay  <= MIN_DELAY_RST;
            cfg_reg.gate_pulse <= GATE_PULSE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/phtd_front.sv
// Input register: saturates power and forms the half-cycle by power-gap product.
module phtd_front (
    input  logic                             aclk,
    input  logic                             load,
    input  logic                             zc_edge,
    input  logic [phtd_pkg::POWER_W-1:0]     power_x10,
    input  phtd_pkg::cfg_t                   cfg,
    output phtd_pkg::front_t                 front
);
    import phtd_pkg::*;

    front_t             front_reg;
    front_t             front_next;
    logic [POWER_W-1:0] p_sat;
    logic [POWER_W-1:0] p_gap;

    always_comb begin
        p_sat = (power_x10 > POWER_FULL) ? POWER_FULL : power_x10;
        p_gap = POWER_FULL - p_sat;
        front_next.zc_edge = zc_edge;
        front_next.p_zero  = (p_sat == '0);
        front_next.p_full  = (p_sat == POWER_FULL);
        front_next.prod    = PROD_W'(cfg.half_cycle) * PROD_W'(p_gap);
    end

    // Payload only: hold unless a new beat is taken
    always_ff @(posedge aclk) begin
        if (load) begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

// File: src/phtd_engine.sv
// Timing engine: debounce, crossing count, firing delay and gate pulse.
module phtd_engine (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             step,
    input  phtd_pkg::front_t                 front,
    input  phtd_pkg::cfg_t                   cfg,
    output logic                             gate,
    output logic                             zc_accepted,
    output logic [phtd_pkg::COUNT_W-1:0]     crossing_count,
    output logic                             fire_pending
);
    import phtd_pkg::*;

    logic [TIME_WIDTH-1:0] since_reg, since_next, since_inc;
    logic [COUNT_W-1:0]    crossings_reg, crossings_next;
    logic                  pending_reg, pending_next;
    logic [DELAY_W-1:0]    delay_reg, delay_next;
    logic [PULSE_W-1:0]    pulse_reg, pulse_next;
    logic                  gate_reg, gate_next;
    logic                  acc_reg;

    logic                  accepted;
    logic [MUL_W-1:0]      mul;
    logic [DELAY_W-1:0]    quot;
    logic [DELAY_W-1:0]    fire_delay;
    logic [PULSE_W-1:0]    pulse_cur;

    always_comb begin
        // Debounce against the counter after this tick's increment
        since_inc = (since_reg == TIME_MAX) ? since_reg : since_reg + 1'b1;
        accepted  = front.zc_edge &&
                    (CMP_W'(since_inc) >= CMP_W'(cfg.half_cycle >> 1));
        since_next     = accepted ? '0 : since_inc;
        crossings_next = crossings_reg + COUNT_W'(accepted);

        mul  = MUL_W'(front.prod) * MUL_W'(RECIP_1000);
        quot = mul[RECIP_SHIFT +: DELAY_W];
        if (front.p_full) begin
            fire_delay = cfg.min_delay;
        end else if (quot < cfg.min_delay) begin
            fire_delay = cfg.min_delay;
        end else begin
            fire_delay = quot;
        end

        pending_next = pending_reg;
        delay_next   = delay_reg;
        if (front.p_zero) begin
            pending_next = 1'b0;
            delay_next   = '0;
        end else if (accepted) begin
            pending_next = 1'b1;
            delay_next   = fire_delay;
        end else if (pending_reg && delay_reg != '0) begin
            delay_next = delay_reg - 1'b1;
        end

        // Fire: restart the pulse from full length
        pulse_cur = pulse_reg;
        if (pending_next && delay_next == '0) begin
            pending_next = 1'b0;
            pulse_cur    = cfg.gate_pulse;
        end

        gate_next  = (pulse_cur != '0);
        pulse_next = gate_next ? pulse_cur - 1'b1 : pulse_cur;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            since_reg     <= '0;
            crossings_reg <= '0;
            pending_reg   <= 1'b0;
            delay_reg     <= '0;
            pulse_reg     <= '0;
        end else if (step) begin
            since_reg     <= since_next;
            crossings_reg <= crossings_next;
            pending_reg   <= pending_next;
            delay_reg     <= delay_next;
            pulse_reg     <= pulse_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (step) begin
            gate_reg <= gate_next;
            acc_reg  <= accepted;
        end
    end

    assign gate           = gate_reg;
    assign zc_accepted    = acc_reg;
    assign crossing_count = crossings_reg;
    assign fire_pending   = pending_reg;

    a_zero_power_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && front.p_zero |=> !pending_reg && delay_reg == '0)
        else $error("zero power left a firing delay armed");

    a_accept_resets_since: assert property (@(posedge aclk) disable iff (!aresetn)
        step && accepted |=> since_reg == '0)
        else $error("accepted crossing did not restart the debounce counter");

    a_count_tracks_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> crossings_reg == $past(crossings_reg) + COUNT_W'($past(accepted)))
        else $error("crossing count out of step with accepted edges");

    a_hold_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(pending_reg) && $stable(delay_reg) && $stable(pulse_reg))
        else $error("timing state moved without a beat");

endmodule

// File: src/phase_angle_triac_dimmer_unit.sv
// A beat taken into the input register passes through the result register to the m_ outputs.
// Throughput: one tick per clock cycle; the input register and the result register
// form a two-stage pipeline that stalls only while m_ready is low.
// The delay divide by 1000 is a constant-reciprocal multiply in the second stage.
// Reset (aresetn low, synchronous) empties both stages, clears all timing state
// and loads half_cycle_us=10000, min_delay_us=100, gate_pulse_us=10.
module phase_angle_triac_dimmer_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_zc_edge,
    input  logic [phtd_pkg::POWER_W-1:0]      s_power_x10,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_gate,
    output logic                              m_zc_accepted,
    output logic [phtd_pkg::COUNT_W-1:0]      m_crossing_count,
    output logic                              m_fire_pending,
    input  logic                              cfg_we,
    input  logic [phtd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [phtd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import phtd_pkg::*;

    cfg_t   cfg;
    front_t front;
    logic   st_valid_reg, st_valid_next;
    logic   out_valid_reg, out_valid_next;
    logic   advance;
    logic   load;
    logic   step;

    // Result slot frees when empty or taken this cycle
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !st_valid_reg || advance;
    assign load    = s_valid && s_ready;
    assign step    = advance && st_valid_reg;

    always_comb begin
        st_valid_next  = load ? 1'b1 : (advance ? 1'b0 : st_valid_reg);
        out_valid_next = advance ? st_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st_valid_reg  <= st_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

    phtd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    phtd_front u_front (
        .aclk      (aclk),
        .load      (load),
        .zc_edge   (s_zc_edge),
        .power_x10 (s_power_x10),
        .cfg       (cfg),
        .front     (front)
    );

    phtd_engine u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .front          (front),
        .cfg            (cfg),
        .gate           (m_gate),
        .zc_accepted    (m_zc_accepted),
        .crossing_count (m_crossing_count),
        .fire_pending   (m_fire_pending)
    );

endmodule
